@@ sv/stbs_pkg.sv @@
`default_nettype none

package stbs_pkg;

  // item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // config register index (paddr[2])
  localparam logic REG_TABLE_LENGTH = 1'b0;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LEN_CFG_W  = 11;

  typedef struct packed {
    logic               op;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] search_key;
  } stbs_in_t;

  typedef struct packed {
    logic       found;
    logic [9:0] found_index;
  } stbs_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DONE
  } stbs_state_t;

endpackage

`default_nettype wire

@@ sv/stbs_ram.sv @@
`default_nettype none

// single-port-write, single-port-read table, registered read
module stbs_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/sorted_table_binary_search.sv @@
`default_nettype none

// Channel   Direction  Handshake                        Payload
// in_       input      in_valid / in_ready              stbs_in_t  (op, index, value, key)
// out_      output     out_valid / out_ready            stbs_out_t (found, found_index)
// cfg_      input      APB psel/penable/pwrite, pready  table_length at byte address 0
//
// A write item is stored at the accepting edge.
// A search makes P probes in S_CMP, one table read each, at most ceil(log2(len+1))
// = 11 at a length of 1024, then reports from S_DONE; a zero length skips S_CMP.
// The result waits in an output register while the next item is taken; a search
// that finishes while it is still full holds in S_DONE until out_ready frees it.
// Reset (rst_n low, synchronous) clears control and table_length, not the table.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire stbs_pkg::stbs_in_t                in_data,
  // results
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output stbs_pkg::stbs_out_t                    out_data,
  // configuration
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [stbs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [stbs_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [stbs_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  import stbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned LEN_W = $clog2(TABLE_DEPTH + 1);
  // bounds: lo in [0, len], hi in [-1, len-1]
  localparam int unsigned PW    = LEN_W + 1;
  localparam logic signed [PW-1:0] ONE_S = 1;

  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic signed [31:0] f);
    logic signed [63:0] w;
    w = 64'(f);
    return w[VALUE_WIDTH-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [LEN_CFG_W-1:0] table_length_r;
  logic                 cfg_wr;
  logic                 cfg_sel_len;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_len = (cfg_paddr[2] == REG_TABLE_LENGTH);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = cfg_sel_len ? CFG_DATA_W'(table_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_wr && cfg_sel_len) begin
      table_length_r <= cfg_pwdata[LEN_CFG_W-1:0];
    end
  end

  // length seen by the search, saturated to the table depth
  logic [31:0]      len32;
  logic [LEN_W-1:0] len_sat;
  assign len32   = (32'(table_length_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                            : 32'(table_length_r);
  assign len_sat = len32[LEN_W-1:0];

  // ---------------- state ----------------
  stbs_state_t                    state_r, state_nxt;
  logic signed [PW-1:0]           lo_r, lo_nxt;
  logic signed [PW-1:0]           hi_r, hi_nxt;
  logic [IDX_W-1:0]               mid_r, mid_nxt;
  logic signed [VALUE_WIDTH-1:0]  key_r, key_nxt;
  logic                           res_found_r, res_found_nxt;
  logic [9:0]                     res_idx_r, res_idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  stbs_out_t                      out_data_r, out_data_nxt;

  // table RAM
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic                           rd_en;
  logic [VALUE_WIDTH-1:0]         rd_data_r;
  logic signed [VALUE_WIDTH-1:0]  entry;

  assign wr_addr = IDX_W'(in_data.entry_index);
  assign entry   = $signed(rd_data_r);

  stbs_ram #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  (VALUE_WIDTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (to_value(in_data.entry_value)),
    .rd_en     (rd_en),
    .rd_addr   (mid_nxt),
    .rd_data_r (rd_data_r)
  );

  // Both follow-up midpoints are formed beside the compare so the next probe
  // address is only a select after it.
  logic signed [PW-1:0] mid_s;
  logic signed [PW-1:0] up_lo, dn_hi;
  logic [PW:0]          up_sum, dn_sum;
  logic [IDX_W-1:0]     up_mid, dn_mid;
  logic                 up_empty, dn_empty;
  logic                 hit, below;

  assign mid_s    = $signed(PW'(mid_r));
  assign up_lo    = mid_s + ONE_S;
  assign dn_hi    = mid_s - ONE_S;
  assign up_sum   = {up_lo[PW-1], up_lo} + {hi_r[PW-1], hi_r};
  assign dn_sum   = {lo_r[PW-1], lo_r} + {dn_hi[PW-1], dn_hi};
  assign up_mid   = up_sum[IDX_W:1];
  assign dn_mid   = dn_sum[IDX_W:1];
  assign up_empty = up_lo > hi_r;
  assign dn_empty = lo_r > dn_hi;
  assign hit      = (entry == key_r);
  assign below    = (entry < key_r);

  // start of a search
  logic signed [PW-1:0] start_hi;
  logic [LEN_W-1:0]     len_m1;
  assign len_m1   = len_sat - LEN_W'(1);
  assign start_hi = $signed({1'b0, len_sat}) - ONE_S;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_WRITE) begin
            // indexes beyond the table are dropped
            wr_en = (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
          end else begin
            key_nxt       = $signed(to_value(in_data.search_key));
            lo_nxt        = '0;
            hi_nxt        = start_hi;
            res_found_nxt = 1'b0;
            res_idx_nxt   = '0;
            if (len_sat == '0) begin
              state_nxt = S_DONE;
            end else begin
              mid_nxt   = IDX_W'(len_m1 >> 1);
              rd_en     = 1'b1;
              state_nxt = S_CMP;
            end
          end
        end
      end
      S_CMP: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = 10'(mid_r);
          state_nxt     = S_DONE;
        end else if (below) begin
          if (up_empty) begin
            state_nxt = S_DONE;
          end else begin
            lo_nxt  = up_lo;
            mid_nxt = up_mid;
            rd_en   = 1'b1;
          end
        end else begin
          if (dn_empty) begin
            state_nxt = S_DONE;
          end else begin
            hi_nxt  = dn_hi;
            mid_nxt = dn_mid;
            rd_en   = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = res_found_r;
          out_data_nxt.found_index = res_idx_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a result appears only out of the finishing state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside S_DONE");

  // probe window is never empty while comparing
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> lo_r <= hi_r)
    else $error("search bounds crossed during compare");

  // probe index lies within the bounds
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (mid_s >= lo_r) && (mid_s <= hi_r))
    else $error("midpoint outside search bounds");

  // a write item never starts a search
  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_WRITE) |=> state_r == S_IDLE)
    else $error("write item left idle");
`endif

endmodule

`default_nettype wire

@@ tb/sv/stbs_result_checker.sv @@
`timescale 1ns / 100ps

module stbs_result_checker
  import stbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  stbs_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  stbs_out_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    outstanding,
  output int                    mismatches
);

  localparam int TABLE_DEPTH  = 1024;
  localparam int REPORT_LIMIT = 100;

  logic signed [31:0]   table_copy [0:TABLE_DEPTH-1];
  logic [LEN_CFG_W-1:0] length_copy;
  stbs_out_t            pending_lookups [$];

  // Midpoint search over the first length_copy entries (saturated to depth).
  function automatic stbs_out_t predict_lookup(input logic signed [31:0] key);
    stbs_out_t res;
    int        span;
    int        lo;
    int        hi;
    int        mid;
    res  = '0;
    span = (length_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_copy);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi && !res.found) begin
      mid = (lo + hi) / 2;
      if (table_copy[mid] == key) begin
        res.found       = 1'b1;
        res.found_index = mid[9:0];
      end else if (table_copy[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  function automatic void flag_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    stbs_out_t want;
    if (!rst_n) begin
      length_copy = '0;
      pending_lookups.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_TABLE_LENGTH) begin
        length_copy = cfg_pwdata[LEN_CFG_W-1:0];
      end
      // retire first: a result can't belong to a search taken at this same edge
      if (out_valid && out_ready) begin
        if (pending_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected result, expected none, actual found=%0d index=%0d",
                     $time, out_data.found, out_data.found_index);
          end
        end else begin
          want = pending_lookups.pop_front();
          if (out_data.found !== want.found) begin
            flag_mismatch("found", want.found, out_data.found);
          end
          if (out_data.found_index !== want.found_index) begin
            flag_mismatch("found_index", want.found_index, out_data.found_index);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_WRITE) begin
          table_copy[in_data.entry_index] = in_data.entry_value;
        end else begin
          pending_lookups.push_back(predict_lookup(in_data.search_key));
        end
      end
      outstanding <= pending_lookups.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  // Sorted data lives in entries 0..FILL_DEPTH-1, the last of them the maximum.
  // The first probe of a search over the whole depth also holds the maximum, so
  // such a search turns into the filled part after two probes. Lengths used are
  // up to FILL_DEPTH, the depth less one, the depth, or above it.
  localparam int FILL_DEPTH    = 256;
  localparam int TOP_PROBE     = TABLE_DEPTH / 2 - 1;
  // settle time that covers the longest search still in flight
  localparam int SETTLE_CYCLES = 16;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES   = 240;
  // longest quiet stretch in a correct run is the hold-off plus one search and
  // a few random gaps; take that many times over
  localparam int STALL_LIMIT   = 4000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 46;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_LENGTH = {REG_TABLE_LENGTH, 2'b00};
  // next register slot up, not decoded by the block
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED     = {~REG_TABLE_LENGTH, 2'b00};

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  stbs_in_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  stbs_out_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int         outstanding;
  int         mismatches;
  int         stall_cycles  = 0;
  int         hold_requests = 0;
  idle_mode_t idle_mode     = IDLE_NONE;

  // stimulus-side image of the table, used only to pick keys and ordered values
  logic signed [31:0] table_image [0:TABLE_DEPTH-1];
  int                 search_span = 0;

  sorted_table_binary_search uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  stbs_result_checker results_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any item, result or config write transfer restarts the count.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("[sorted_table_binary_search] ERROR");
    $finish;
  end

  function automatic int sender_gap_pct();
    return (idle_mode == IDLE_SENDER) ? 64 : (idle_mode == IDLE_BOTH) ? 31 : 0;
  endfunction

  function automatic int receiver_stall_pct();
    return (idle_mode == IDLE_RECEIVER) ? 64 : (idle_mode == IDLE_BOTH) ? 31 : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per idle mode, plus a long hold-off on request.
  // The hold is counted here so the sender keeps offering items meanwhile.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left    = 0;
    int holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Every item task returns right after the edge that took the transfer,
  // with valid still high, so back-to-back items need no extra edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input stbs_in_t item);
    while ($urandom_range(0, 99) < sender_gap_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_entry(input int idx, input logic signed [31:0] value);
    stbs_in_t item;
    item.op          = OP_WRITE;
    item.entry_index = idx[9:0];
    item.entry_value = value;
    item.search_key  = $urandom();   // don't-care on a write
    table_image[idx] = value;
    send_item(item);
  endtask

  task automatic search_for(input logic signed [31:0] key);
    stbs_in_t item;
    item.op          = OP_SEARCH;
    item.entry_index = 10'($urandom());   // don't-care on a search
    item.entry_value = $urandom();
    item.search_key  = key;
    send_item(item);
  endtask

  // Wait until every search has reported and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Bits above the 11-bit field carry junk to show they're dropped.
  task automatic set_length(input int len);
    logic [CFG_DATA_W-1:0] word;
    word                  = $urandom();
    word[LEN_CFG_W-1:0]   = len[LEN_CFG_W-1:0];
    cfg_write(ADDR_TABLE_LENGTH, word);
    search_span = (len > FILL_DEPTH) ? FILL_DEPTH : len;
  endtask

  // Keys: mostly hits on the searched range, then near misses, edges, noise.
  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] key;
    int                 r;
    r = $urandom_range(0, 99);
    if (search_span > 0 && r < 55) begin
      key = table_image[$urandom_range(0, search_span - 1)];
    end else if (search_span > 0 && r < 75) begin
      key = table_image[$urandom_range(0, search_span - 1)];
      key = $urandom_range(0, 1) ? key + 32'sd1 : key - 32'sd1;
    end else if (r < 87) begin
      case ($urandom_range(0, 3))
        0:       key = VAL_MIN;
        1:       key = VAL_MAX;
        2:       key = 32'sd0;
        default: key = -32'sd1;
      endcase
    end else begin
      key = $urandom();
    end
    return key;
  endfunction

  // Overwrite one entry with a value between its neighbors, keeping order.
  // The maximum at the top of the filled part stays in place.
  task automatic ordered_write();
    int                 idx;
    longint             lower;
    longint             upper;
    longint             pick;
    longint unsigned    range_w;
    longint unsigned    r64;
    logic signed [31:0] value;
    idx   = $urandom_range(0, FILL_DEPTH - 2);
    lower = (idx > 0) ? longint'(table_image[idx - 1]) : longint'(VAL_MIN);
    upper = (idx < TABLE_DEPTH - 1) ? longint'(table_image[idx + 1]) : longint'(VAL_MAX);
    if (lower <= upper) begin
      range_w = upper - lower + 1;
      r64     = {$urandom(), $urandom()};
      pick    = lower + longint'(r64 % range_w);
    end else begin
      pick = lower;   // neighbors already out of order from a noise write
    end
    value = pick[31:0];
    write_entry(idx, value);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      ordered_write();
    end else if (r < 15) begin
      // noise: arbitrary value inside the filled part, leaves it unsorted
      write_entry($urandom_range(0, FILL_DEPTH - 2), $urandom());
    end else begin
      search_for(pick_key());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int     phase_len [NUM_PHASES];
    longint acc;
    logic signed [31:0] fill_value;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed -----------------------------------------------------------
    // length is still at its reset value of zero: must miss without a probe
    search_for(32'sd0);

    // small sorted table spanning both extremes
    write_entry(0, VAL_MIN);
    write_entry(1, -32'sd1000);
    write_entry(2, -32'sd1);
    write_entry(3, 32'sd0);
    write_entry(4, 32'sd1);
    write_entry(5, 32'sd77);
    write_entry(6, 32'sd5000);
    write_entry(7, VAL_MAX);
    drain();
    set_length(8);

    search_for(VAL_MIN);
    search_for(VAL_MAX);
    search_for(32'sd0);
    search_for(32'sd77);
    search_for(-32'sd1000);
    search_for(32'sd5000);
    search_for(32'sd2);             // absent, between entries
    search_for(VAL_MIN + 32'sd1);   // absent, just above the minimum
    search_for(-32'sd5);
    drain();

    // write to an undecoded address: length must stay at 8
    cfg_write(ADDR_UNMAPPED, $urandom());
    search_for(32'sd1);

    // break the order: the probe path now skips past entry 4
    write_entry(3, VAL_MAX);
    search_for(32'sd1);
    drain();

    // --- fill the sorted part in ascending order (duplicates allowed) ------
    acc = longint'(VAL_MIN);
    for (int i = 0; i < FILL_DEPTH; i++) begin
      if (i == FILL_DEPTH - 1 || acc > longint'(VAL_MAX)) begin
        acc = longint'(VAL_MAX);
      end
      fill_value = acc[31:0];
      write_entry(i, fill_value);
      acc = acc + $urandom_range(0, 16000000);
    end
    // first probe of a search over the whole depth
    write_entry(TOP_PROBE, VAL_MAX);
    drain();

    // --- random phases ------------------------------------------------------
    // full, minimal, saturated, tiny, full-1, zero, then one random inside the
    // sorted part and one random above the depth
    phase_len[0] = TABLE_DEPTH;
    phase_len[1] = 1;
    phase_len[2] = (1 << LEN_CFG_W) - 1;
    phase_len[3] = 2;
    phase_len[4] = TABLE_DEPTH - 1;
    phase_len[5] = 0;
    phase_len[6] = $urandom_range(3, FILL_DEPTH);
    phase_len[7] = $urandom_range(TABLE_DEPTH + 1, (1 << LEN_CFG_W) - 1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_length(phase_len[phase]);
      idle_mode = idle_mode_t'(phase % 4);
      // receiver goes dark while the sender keeps pushing: fills the output
      // register and the search engine, then in_ready must drop
      if (phase == 4) begin
        hold_requests++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
      end
      drain();
    end

    idle_mode = IDLE_NONE;
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[sorted_table_binary_search] OK");
    end else begin
      $display("[sorted_table_binary_search] ERROR");
    end
    $finish;
  end

endmodule
